// ----- hw/rtl/dsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dsf_pkg - shared definitions for the damped spring force block
// Register indexes of the configuration port.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STIFFNESS    = 2'd0;
  localparam cfg_idx_t REG_REST_LENGTH  = 2'd1;
  localparam cfg_idx_t REG_DAMPING_GAIN = 2'd2;

endpackage

// ----- hw/rtl/dsf_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// dsf_sqrt_cell - one digit of the integer square root
// Bring in one bit pair, try the subtract, shift one root bit in.
// ----------------------------------------------------------------------------
module dsf_sqrt_cell #(
  parameter int RW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW+1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [1:0]    pair,
  output logic [RW+1:0] rem_o,
  output logic [RW-1:0] root_o
);
  logic [RW+3:0] r4;
  logic [RW+3:0] test;
  logic          ge;

  always_comb begin
    r4   = {rem_i, pair};
    test = {2'b00, root_i, 2'b01};
    ge   = (r4 >= test);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? (r4[RW+1:0] - test[RW+1:0]) : r4[RW+1:0];
      root_o <= {root_i[RW-2:0], ge};
    end
  end
endmodule

// ----- hw/rtl/dsf_div_cell.sv -----
// ----------------------------------------------------------------------------
// dsf_div_cell - one step of restoring division
// Shift in one dividend bit, subtract the divisor when it fits.
// ----------------------------------------------------------------------------
module dsf_div_cell #(
  parameter int DW = 33,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] q_i,
  input  logic          bit_i,
  input  logic [DW-1:0] den,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] q_o
);
  logic [DW:0] r2;
  logic        ge;

  always_comb begin
    r2 = {rem_i, bit_i};
    ge = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? (r2[DW-1:0] - den) : r2[DW-1:0];
      q_o   <= {q_i[QW-2:0], ge};
    end
  end
endmodule

// ----- hw/rtl/dsf_mulq.sv -----
// ----------------------------------------------------------------------------
// dsf_mulq - registered sign-magnitude fixed point multiply
// Multiply magnitudes, drop the fraction bits (toward zero), hold the sign.
// ----------------------------------------------------------------------------
module dsf_mulq #(
  parameter int AW = 32,
  parameter int BW = 33,
  parameter int FB = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AW-1:0]      a_mag,
  input  logic               a_neg,
  input  logic [BW-1:0]      b_mag,
  input  logic               b_neg,
  output logic [AW+BW-FB-1:0] p_mag,
  output logic               p_neg
);
  logic [AW+BW-1:0] prod;

  assign prod = a_mag * b_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      p_mag <= prod[AW+BW-1:FB];
      p_neg <= a_neg ^ b_neg;
    end
  end
endmodule

// ----- hw/rtl/damped_spring_force.sv -----
// ----------------------------------------------------------------------------
// damped_spring_force - pipelined damped spring force, signed fixed point
//
// Each slave beat carries both end points of one spring (positions and
// velocities); each master beat returns the force on the first particle:
//   F = stiffness*(L - rest_length)*d/L + damping_gain*w
// with d, w the relative position and velocity and L = |d|. The second
// particle takes -F. Results saturate to the signed data range. A spring
// of zero length returns a zero force with tuser (degenerate) set.
// Configure stiffness, rest_length and damping_gain through cfg_we /
// cfg_index / cfg_data while the pipe is empty; unknown indexes are dropped.
// Throughput: one beat per cycle while the receiver takes beats. The
// pipe holds the square root row (one cell per root bit) and the
// divider rows (one cell per quotient bit).
// A stalled receiver freezes the whole pipe; s_tready is low only while
// the output register holds a beat that is not taken. Reset clears the
// configuration registers and all valid bits at once.
// ----------------------------------------------------------------------------
module damped_spring_force #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  dsf_pkg::cfg_idx_t                    cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // first_pos_x/y/z, second_pos_x/y/z, first_vel_x/y/z, second_vel_x/y/z
  input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // force_x, force_y, force_z
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
  // degenerate
  output logic                                 m_tuser
);
  import dsf_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int W1  = DW + 1;          // differences, root
  localparam int SW  = 2 * W1;          // squared length
  localparam int NS  = W1;              // sqrt cells
  localparam int ND  = F + 1;           // divider cells per axis
  localparam int PW  = 2 * DW + 1 - F;  // spring and damping product width
  localparam int P   = 6 + NS + ND;     // pipeline depth
  localparam int OW  = ((3*DW+7)/8)*8;
  localparam logic signed [PW+1:0] SAT_MAX = (PW+2)'((64'(1) << (DW-1)) - 1);
  localparam logic signed [PW+1:0] SAT_MIN = -SAT_MAX - (PW+2)'(1);

  // configuration
  logic [DW-2:0] stiffness;
  logic [DW-2:0] rest_length;
  logic [DW-1:0] damping_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness    <= '0;
      rest_length  <= '0;
      damping_gain <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STIFFNESS:    stiffness    <= cfg_data[DW-2:0];
        REG_REST_LENGTH:  rest_length  <= cfg_data[DW-2:0];
        REG_DAMPING_GAIN: damping_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: freeze everything while the output beat waits
  logic         en;
  logic [P-1:0] vld;

  assign en       = !vld[P-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[P-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[P-2:0], s_tvalid};
    end
  end

  // stage 1: relative position and velocity as sign and magnitude
  logic [W1-1:0] d_c    [3];
  logic [W1-1:0] w_c    [3];
  logic [W1-1:0] s1_mag [3];
  logic          s1_neg [3];
  logic [W1-1:0] s1_wm  [3];
  logic          s1_wn  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_c[a] = {s_tdata[(a+3)*DW+DW-1], s_tdata[(a+3)*DW +: DW]}
             - {s_tdata[a*DW+DW-1], s_tdata[a*DW +: DW]};
      w_c[a] = {s_tdata[(a+9)*DW+DW-1], s_tdata[(a+9)*DW +: DW]}
             - {s_tdata[(a+6)*DW+DW-1], s_tdata[(a+6)*DW +: DW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s1_neg[a] <= d_c[a][W1-1];
        s1_mag[a] <= d_c[a][W1-1] ? -d_c[a] : d_c[a];
        s1_wn[a]  <= w_c[a][W1-1];
        s1_wm[a]  <= w_c[a][W1-1] ? -w_c[a] : w_c[a];
      end
    end
  end

  // stage 2: squares
  logic [SW-1:0] s2_sq  [3];
  logic [W1-1:0] s2_mag [3];
  logic          s2_neg [3];
  logic [W1-1:0] s2_wm  [3];
  logic          s2_wn  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s2_sq[a]  <= s1_mag[a] * s1_mag[a];
        s2_mag[a] <= s1_mag[a];
        s2_neg[a] <= s1_neg[a];
        s2_wm[a]  <= s1_wm[a];
        s2_wn[a]  <= s1_wn[a];
      end
    end
  end

  // stage 3 and the sqrt row: payload rides beside the cells
  logic [SW-1:0] ps_sum [0:NS];
  logic [W1-1:0] ps_mag [0:NS][3];
  logic          ps_neg [0:NS][3];
  logic [W1-1:0] ps_wm  [0:NS][3];
  logic          ps_wn  [0:NS][3];
  logic          ps_z   [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      ps_sum[0] <= s2_sq[0] + s2_sq[1] + s2_sq[2];
      ps_z[0]   <= (s2_mag[0] == '0) && (s2_mag[1] == '0) && (s2_mag[2] == '0);
      for (int a = 0; a < 3; a++) begin
        ps_mag[0][a] <= s2_mag[a];
        ps_neg[0][a] <= s2_neg[a];
        ps_wm[0][a]  <= s2_wm[a];
        ps_wn[0][a]  <= s2_wn[a];
      end
      for (int j = 0; j < NS; j++) begin
        ps_sum[j+1] <= ps_sum[j];
        ps_z[j+1]   <= ps_z[j];
        for (int a = 0; a < 3; a++) begin
          ps_mag[j+1][a] <= ps_mag[j][a];
          ps_neg[j+1][a] <= ps_neg[j][a];
          ps_wm[j+1][a]  <= ps_wm[j][a];
          ps_wn[j+1][a]  <= ps_wn[j][a];
        end
      end
    end
  end

  logic [W1+1:0] sq_rem  [1:NS];
  logic [W1-1:0] sq_root [1:NS];

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    if (j == 0) begin : g_head
      dsf_sqrt_cell #(.RW(W1)) u_cell (
        .clk(clk), .en(en), .rem_i('0), .root_i('0),
        .pair(ps_sum[j][2*(NS-1-j) +: 2]),
        .rem_o(sq_rem[j+1]), .root_o(sq_root[j+1])
      );
    end else begin : g_body
      dsf_sqrt_cell #(.RW(W1)) u_cell (
        .clk(clk), .en(en), .rem_i(sq_rem[j]), .root_i(sq_root[j]),
        .pair(ps_sum[j][2*(NS-1-j) +: 2]),
        .rem_o(sq_rem[j+1]), .root_o(sq_root[j+1])
      );
    end
  end

  // length error, kept as sign and magnitude
  logic [DW+1:0] e_c;
  logic [W1-1:0] e_mag_c;

  always_comb begin
    e_c     = {1'b0, sq_root[NS]} - {3'b000, rest_length};
    e_mag_c = e_c[DW+1] ? W1'(-e_c) : e_c[W1-1:0];
  end

  // divider rows: u = |d| * 2^F / L, one quotient bit per cell
  logic [W1-1:0] dv_len [1:ND];
  logic [W1-1:0] dv_em  [1:ND];
  logic          dv_en  [1:ND];
  logic          dv_neg [1:ND][3];
  logic [W1-1:0] dv_wm  [1:ND][3];
  logic          dv_wn  [1:ND][3];
  logic          dv_z   [1:ND];
  logic [W1-1:0] dv_rem [1:ND][3];
  logic [ND-1:0] dv_q   [1:ND][3];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[1] <= sq_root[NS];
      dv_em[1]  <= e_mag_c;
      dv_en[1]  <= e_c[DW+1];
      dv_z[1]   <= ps_z[NS];
      for (int a = 0; a < 3; a++) begin
        dv_neg[1][a] <= ps_neg[NS][a];
        dv_wm[1][a]  <= ps_wm[NS][a];
        dv_wn[1][a]  <= ps_wn[NS][a];
      end
      for (int k = 1; k < ND; k++) begin
        dv_len[k+1] <= dv_len[k];
        dv_em[k+1]  <= dv_em[k];
        dv_en[k+1]  <= dv_en[k];
        dv_z[k+1]   <= dv_z[k];
        for (int a = 0; a < 3; a++) begin
          dv_neg[k+1][a] <= dv_neg[k][a];
          dv_wm[k+1][a]  <= dv_wm[k][a];
          dv_wn[k+1][a]  <= dv_wn[k][a];
        end
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar k = 0; k < ND; k++) begin : g_div
      if (k == 0) begin : g_head
        // the quotient fits in ND bits, so start from |d| >> 1
        dsf_div_cell #(.DW(W1), .QW(ND)) u_cell (
          .clk(clk), .en(en),
          .rem_i(ps_mag[NS][a] >> 1), .q_i('0), .bit_i(ps_mag[NS][a][0]),
          .den(sq_root[NS]),
          .rem_o(dv_rem[k+1][a]), .q_o(dv_q[k+1][a])
        );
      end else begin : g_body
        dsf_div_cell #(.DW(W1), .QW(ND)) u_cell (
          .clk(clk), .en(en),
          .rem_i(dv_rem[k][a]), .q_i(dv_q[k][a]), .bit_i(1'b0),
          .den(dv_len[k]),
          .rem_o(dv_rem[k+1][a]), .q_o(dv_q[k+1][a])
        );
      end
    end
  end

  // stage A: ku = stiffness * u
  logic [DW-1:0] ka_mag [3];
  logic          ka_neg [3];
  logic [W1-1:0] ka_em;
  logic          ka_en;
  logic [W1-1:0] ka_wm  [3];
  logic          ka_wn  [3];
  logic          ka_z;

  for (genvar a = 0; a < 3; a++) begin : g_ku
    dsf_mulq #(.AW(DW-1), .BW(ND), .FB(F)) u_mul (
      .clk(clk), .en(en),
      .a_mag(stiffness), .a_neg(1'b0),
      .b_mag(dv_q[ND][a]), .b_neg(dv_neg[ND][a]),
      .p_mag(ka_mag[a]), .p_neg(ka_neg[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ka_em <= dv_em[ND];
      ka_en <= dv_en[ND];
      ka_z  <= dv_z[ND];
      for (int a = 0; a < 3; a++) begin
        ka_wm[a] <= dv_wm[ND][a];
        ka_wn[a] <= dv_wn[ND][a];
      end
    end
  end

  // stage B: spring term ku*e and damping term gain*w side by side
  logic [DW-1:0] dmp_mag;
  logic [PW-1:0] sp_mag [3];
  logic          sp_neg [3];
  logic [PW-1:0] dm_mag [3];
  logic          dm_neg [3];
  logic          kb_z;

  assign dmp_mag = damping_gain[DW-1] ? -damping_gain : damping_gain;

  for (genvar a = 0; a < 3; a++) begin : g_term
    dsf_mulq #(.AW(DW), .BW(W1), .FB(F)) u_spring (
      .clk(clk), .en(en),
      .a_mag(ka_mag[a]), .a_neg(ka_neg[a]), .b_mag(ka_em), .b_neg(ka_en),
      .p_mag(sp_mag[a]), .p_neg(sp_neg[a])
    );
    dsf_mulq #(.AW(DW), .BW(W1), .FB(F)) u_damp (
      .clk(clk), .en(en),
      .a_mag(dmp_mag), .a_neg(damping_gain[DW-1]),
      .b_mag(ka_wm[a]), .b_neg(ka_wn[a]),
      .p_mag(dm_mag[a]), .p_neg(dm_neg[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kb_z <= ka_z;
    end
  end

  // output stage: add, saturate, zero on a degenerate spring
  logic signed [PW+1:0] tot [3];
  logic [DW-1:0]        frc [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tot[a] = (sp_neg[a] ? -$signed({2'b00, sp_mag[a]}) : $signed({2'b00, sp_mag[a]}))
             + (dm_neg[a] ? -$signed({2'b00, dm_mag[a]}) : $signed({2'b00, dm_mag[a]}));
      if (kb_z)              frc[a] = '0;
      else if (tot[a] > SAT_MAX) frc[a] = SAT_MAX[DW-1:0];
      else if (tot[a] < SAT_MIN) frc[a] = SAT_MIN[DW-1:0];
      else                   frc[a] = tot[a][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OW'({frc[2], frc[1], frc[0]});
      m_tuser <= kb_z;
    end
  end

  // a degenerate spring carries no force
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate beat with nonzero force");

  // a zero squared length gives a zero root
  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    vld[2+NS] && ps_z[NS] |-> sq_root[NS] == '0)
    else $error("nonzero root for zero length");

  // the x and z unit vector components never exceed one
  a_unit_x: assert property (@(posedge clk) disable iff (rst)
    vld[2+NS+ND] && !dv_z[ND] |-> dv_q[ND][0] <= ND'(1) << F)
    else $error("x quotient out of range");

  a_unit_z: assert property (@(posedge clk) disable iff (rst)
    vld[2+NS+ND] && !dv_z[ND] |-> dv_q[ND][2] <= ND'(1) << F)
    else $error("z quotient out of range");

endmodule
